/* hw/rtl/ipv4_five_tuple_extractor_macros.svh */
// Assertion macros for the IPv4 five-tuple extractor checker.
// No dependencies; included by the checker file only.
`ifndef IPV4_FIVE_TUPLE_EXTRACTOR_MACROS_SVH
`define IPV4_FIVE_TUPLE_EXTRACTOR_MACROS_SVH

// Same-cycle implication, masked while reset is asserted
`define FTE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted
`define FTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked through reset as well
`define FTE_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/fte_pkg.sv */
// Shared types and constants for the IPv4 five-tuple extractor.
// No dependencies; imported by every RTL module of the block.
package fte_pkg;

    localparam logic [6:0]  OFFSET_MAX    = 7'd127;
    localparam logic [6:0]  OFF_ETYPE_HI  = 7'd12;
    localparam logic [6:0]  OFF_ETYPE_LO  = 7'd13;
    localparam logic [6:0]  OFF_IHL       = 7'd14;
    localparam logic [6:0]  OFF_PROTO     = 7'd23;
    localparam logic [6:0]  OFF_SA_FIRST  = 7'd26;
    localparam logic [6:0]  OFF_SA_LAST   = 7'd29;
    localparam logic [6:0]  OFF_DA_FIRST  = 7'd30;
    localparam logic [6:0]  OFF_DA_LAST   = 7'd33;
    localparam logic [3:0]  IHL_MASK      = 4'hf;
    localparam logic [15:0] ETH_IPV4      = 16'h0800;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;

    // One frame byte as held in the input register
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    // One flow key as held in the result register
    typedef struct packed {
        logic [15:0] l4_dport;
        logic [15:0] l4_sport;
        logic [7:0]  ip_protocol;
        logic [31:0] ip_daddr;
        logic [31:0] ip_saddr;
    } flow_key_t;

endpackage

/* hw/rtl/fte_in_reg.sv */
// Input register of the IPv4 five-tuple extractor: holds one frame byte.
// Depends on fte_pkg.
module fte_in_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  fte_pkg::byte_item_t s_item,
    output logic               hold_valid,
    output fte_pkg::byte_item_t hold_item,
    input  logic               hold_take
);
    import fte_pkg::*;

    logic       valid_reg;
    byte_item_t item_reg;

    // Accept while empty or while the held item leaves this cycle
    assign s_tready   = !valid_reg || hold_take;
    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;

    // Track occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (hold_take) begin
            valid_reg <= 1'b0;
        end
    end

    // Load the payload on accept
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

endmodule

/* hw/rtl/fte_parser.sv */
// Header capture logic and result register of the IPv4 five-tuple extractor.
// Depends on fte_pkg.
module fte_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  fte_pkg::byte_item_t in_item,
    output logic                in_take,
    output logic                m_tvalid,
    input  logic                m_tready,
    output fte_pkg::flow_key_t  m_key,
    output logic                m_short
);
    import fte_pkg::*;

    logic [6:0]  offset_reg, offset_next;
    logic [15:0] etype_reg, etype_next;
    logic [3:0]  hw_reg, hw_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] sa_reg, sa_next;
    logic [31:0] da_reg, da_next;
    logic [15:0] sp_reg, sp_next;
    logic [15:0] dp_reg, dp_next;
    logic [6:0]  port_off;
    logic [7:0]  b;
    logic [6:0]  idx;
    logic        out_valid_reg;
    flow_key_t   key_reg, key_next;
    logic        short_reg, short_next;
    logic        out_free;
    logic        load_key;

    assign b   = in_item.data_byte;
    assign idx = offset_reg;

    // Take a byte unless it closes a frame while the result register is full and not being taken
    assign out_free = !out_valid_reg || m_tready;
    assign in_take  = in_valid && (!in_item.last_byte || out_free);
    assign load_key = in_take && in_item.last_byte;

    // Update capture registers with the current byte
    always_comb begin
        etype_next = etype_reg;
        hw_next    = hw_reg;
        proto_next = proto_reg;
        sa_next    = sa_reg;
        da_next    = da_reg;
        sp_next    = sp_reg;
        dp_next    = dp_reg;
        if (idx == OFF_ETYPE_HI || idx == OFF_ETYPE_LO) begin
            etype_next = {etype_reg[7:0], b};
        end
        if (idx == OFF_IHL) begin
            hw_next = b[3:0] & IHL_MASK;
        end
        if (idx == OFF_PROTO) begin
            proto_next = b;
        end
        if (idx >= OFF_SA_FIRST && idx <= OFF_SA_LAST) begin
            sa_next = {sa_reg[23:0], b};
        end
        if (idx >= OFF_DA_FIRST && idx <= OFF_DA_LAST) begin
            da_next = {da_reg[23:0], b};
        end
        port_off = OFF_IHL + {1'b0, hw_next, 2'b00};
        if (idx >= OFF_IHL) begin
            if (idx == port_off || idx == port_off + 7'd1) begin
                sp_next = {sp_reg[7:0], b};
            end
            if (idx == port_off + 7'd2 || idx == port_off + 7'd3) begin
                dp_next = {dp_reg[7:0], b};
            end
        end
        offset_next = (idx < OFFSET_MAX) ? idx + 7'd1 : idx;
    end

    // Build the flow key from the updated captures
    always_comb begin
        key_next   = '0;
        short_next = 1'b0;
        if (idx < OFF_ETYPE_LO) begin
            short_next = 1'b1;
        end else if (etype_next == ETH_IPV4) begin
            if (idx >= OFF_SA_LAST) begin
                key_next.ip_saddr = sa_next;
            end
            if (idx >= OFF_DA_LAST) begin
                key_next.ip_daddr = da_next;
            end else begin
                short_next = 1'b1;
            end
            if (idx >= OFF_PROTO) begin
                key_next.ip_protocol = proto_next;
                if (proto_next == PROTO_TCP || proto_next == PROTO_UDP) begin
                    if (idx >= port_off + 7'd1) begin
                        key_next.l4_sport = sp_next;
                    end
                    if (idx >= port_off + 7'd3) begin
                        key_next.l4_dport = dp_next;
                    end else begin
                        short_next = 1'b1;
                    end
                end
            end else begin
                short_next = 1'b1;
            end
        end
    end

    // Advance frame state; clear it after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn || load_key) begin
            offset_reg <= '0;
            etype_reg  <= '0;
            hw_reg     <= '0;
            proto_reg  <= '0;
            sa_reg     <= '0;
            da_reg     <= '0;
            sp_reg     <= '0;
            dp_reg     <= '0;
        end else if (in_take) begin
            offset_reg <= offset_next;
            etype_reg  <= etype_next;
            hw_reg     <= hw_next;
            proto_reg  <= proto_next;
            sa_reg     <= sa_next;
            da_reg     <= da_next;
            sp_reg     <= sp_next;
            dp_reg     <= dp_next;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_key) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_key) begin
            key_reg   <= key_next;
            short_reg <= short_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_key    = key_reg;
    assign m_short  = short_reg;

endmodule

/* hw/rtl/ipv4_five_tuple_extractor.sv */
// Top level of the IPv4 five-tuple extractor.
// Depends on fte_pkg, fte_in_reg and fte_parser.
//
// Usage:
//   The s_ channel carries an Ethernet frame one byte per item, with
//   s_tlast high on the final byte. The m_ channel gives one flow key per
//   frame, issued for the item that carries s_tlast.
//   Throughput is one byte per cycle while no key waits on m_tready: each
//   byte passes through an input register and a single capture step, and
//   frames may follow each other with no gap.
//   The key is offered on m_ after the last byte has passed the input
//   register and then the result register.
//   Stall: while a key waits on m_tready, bytes of the next frame keep
//   flowing; only the next last byte waits in the input register, and
//   s_tready drops behind it until the pending key is taken.
//   Reset: aresetn low clears frame state and both valid flags; after
//   reset the block expects the first byte of a new frame.
//   Keys with absent fields carry zeros there; m_tuser flags frames that
//   ended before a needed field.
module ipv4_five_tuple_extractor (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,   // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] ip_saddr, [63:32] ip_daddr, [71:64] ip_protocol,
    // [87:72] l4_sport, [103:88] l4_dport
    output logic [103:0] m_tdata,
    output logic [0:0]   m_tuser    // [0] short_frame
);
    import fte_pkg::*;

    byte_item_t s_item;
    byte_item_t hold_item;
    logic       hold_valid;
    logic       hold_take;
    flow_key_t  key;
    logic       short_flag;

    assign s_item.data_byte = s_tdata;
    assign s_item.last_byte = s_tlast;

    fte_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .hold_valid (hold_valid),
        .hold_item  (hold_item),
        .hold_take  (hold_take)
    );

    fte_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (hold_valid),
        .in_item  (hold_item),
        .in_take  (hold_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_key    (key),
        .m_short  (short_flag)
    );

    // Pack the key, ip_saddr in the lowest bits and l4_dport in the highest
    assign m_tdata = {key.l4_dport, key.l4_sport, key.ip_protocol,
                      key.ip_daddr, key.ip_saddr};
    assign m_tuser = short_flag;

endmodule

/* hw/rtl/fte_checker.sv */
// Port-level checker for the IPv4 five-tuple extractor, bound to the top.
// Depends on fte_pkg and ipv4_five_tuple_extractor_macros.svh.
`include "ipv4_five_tuple_extractor_macros.svh"

module fte_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata,
    input logic [0:0]   m_tuser
);
    import fte_pkg::*;

    logic         m_stall;
    logic [104:0] m_word;
    logic         port_set;
    logic         proto_l4;

    assign m_stall  = m_tvalid && !m_tready;
    assign m_word   = {m_tuser, m_tdata};
    assign port_set = m_tvalid && (m_tdata[103:72] != 32'd0);
    assign proto_l4 = (m_tdata[71:64] == PROTO_TCP) || (m_tdata[71:64] == PROTO_UDP);

    // A stalled result stays offered
    `FTE_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_stall, m_tvalid, "m_tvalid dropped under stall")

    // A stalled result keeps its payload
    `FTE_ASSERT_NEXT(a_m_stable, aclk, aresetn, m_stall, $stable(m_word), "m payload moved")

    // Ports are only reported for TCP or UDP
    `FTE_ASSERT_IMPL(a_port_proto, aclk, aresetn, port_set, proto_l4, "ports without TCP or UDP")

    // Reset empties the result register
    `FTE_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid, "result after reset")

endmodule

bind ipv4_five_tuple_extractor fte_checker u_fte_checker (.*);
